// ===== hw/rtl/ftb8_pkg.sv =====
// ----------------------------------------------------------------------------
// ftb8_pkg
// types and constants shared by the 8x8 font text blitter and its channels
// ----------------------------------------------------------------------------
package ftb8_pkg;

    localparam logic       KIND_FONT   = 1'b0;
    localparam logic       KIND_CHAR   = 1'b1;
    localparam logic [7:0] NUL_CODE    = 8'h00;
    localparam logic [15:0] CELL_WIDTH = 16'd8;
    localparam logic [8:0] LIMIT_FULL  = 9'd256;
    localparam int         CODE_COUNT  = 256;

    typedef struct packed {
        logic       kind;
        logic [10:0] font_address;
        logic [7:0] font_bits;
        logic [7:0] character;
        logic       string_start;
        logic [8:0] x;
        logic [7:0] y;
        logic [7:0] color;
        logic [7:0] max_chars;
    } ftb8_in_t;

    typedef struct packed {
        logic [15:0] address;
        logic [7:0]  pixel_mask;
        logic [7:0]  pixel_color;
        logic        last_row;
        logic        string_done;
        logic [8:0]  chars_consumed;
    } ftb8_out_t;

    typedef logic [15:0] ftb8_cfg_t;

    typedef enum logic {
        ST_IDLE,
        ST_ROWS
    } ftb8_state_t;

endpackage

// ===== hw/rtl/ftb8_stream_if.sv =====
// ----------------------------------------------------------------------------
// ftb8_stream_if
// valid/ready channel carrying one payload per transaction
// ----------------------------------------------------------------------------
interface ftb8_stream_if #(
    parameter type payload_t = logic
);

    logic     valid;
    logic     ready;
    payload_t data;

    modport source (
        output valid,
        output data,
        input  ready
    );

    modport sink (
        input  valid,
        input  data,
        output ready
    );

endinterface

// ===== hw/rtl/font_text_blitter_8x8.sv =====
// ----------------------------------------------------------------------------
// font_text_blitter_8x8
// draws strings in a bitmap font as masked row writes into a byte-per-pixel
// frame
// ----------------------------------------------------------------------------
// in_ch carries font loads and string characters, one per transaction. a font
// load writes one byte of the glyph memory and returns nothing. a character
// of an open string returns GLYPH_ROWS row writes on out_ch (offset, mask,
// colour), the last one flagged last_row; a NUL returns one mask-zero write.
// characters with no open string return nothing. cfg_ch sets frame_base; the
// user must write it only while idle; the block itself does not enforce this.
// a drawn character holds in_ch while its rows issue: the glyph memory read
// port gives one row per cycle while out_ch is not stalled, and the next
// transaction is taken in the cycle the last row is read. a font load or a
// character with no open string leaves in_ch ready. the first row write passes
// the job registers, the memory read and s1 stage, then the output register.
// when out_ch stalls, the row sequencer and the memory read stage hold, and
// in_ch waits while a character still has rows to issue; once idle it takes
// one more character and then waits; font loads keep flowing until then.
// reset clears the string state, frame_base and the channels; the glyph
// memory is not cleared and needs no sweep, so in_ch is ready straight away.
// ----------------------------------------------------------------------------
module font_text_blitter_8x8
    import ftb8_pkg::*;
#(
    parameter int LINE_PITCH  = 320,
    parameter int GLYPH_ROWS  = 8,
    parameter int GLYPH_COUNT = 256
) (
    input  logic          clk,
    input  logic          rst_n,
    ftb8_stream_if.sink   in_ch,
    ftb8_stream_if.source out_ch,
    ftb8_stream_if.sink   cfg_ch
);

    localparam int STORE_SIZE = GLYPH_COUNT * GLYPH_ROWS;
    localparam int STORE_AW   = $clog2(STORE_SIZE);
    localparam int FA_W       = (STORE_AW + 1 > 11) ? STORE_AW + 1 : 11;
    localparam int GC_W       = $clog2(GLYPH_COUNT);
    localparam int RL_W       = $clog2(GLYPH_ROWS + 1);

    logic [7:0] glyph_mem [STORE_SIZE];
    logic [7:0] rd_data_reg;

    logic [GC_W-1:0] code_mod [CODE_COUNT];

    ftb8_state_t state_reg, state_next;
    logic [15:0] frame_base_reg, frame_base_next;
    logic [15:0] origin_reg, origin_next;
    logic [8:0]  left_reg, left_next;
    logic [8:0]  drawn_reg, drawn_next;
    logic [7:0]  color_reg, color_next;
    logic        active_reg, active_next;

    logic [RL_W-1:0]     rows_left_reg, rows_left_next;
    logic                job_nul_reg, job_nul_next;
    logic                job_done_reg, job_done_next;
    logic [15:0]         job_addr_reg, job_addr_next;
    logic [STORE_AW-1:0] job_gidx_reg, job_gidx_next;

    logic      s1_valid_reg, s1_valid_next;
    logic      s1_nul_reg, s1_nul_next;
    ftb8_out_t s1_reg, s1_next;
    logic      out_valid_reg, out_valid_next;
    ftb8_out_t out_reg, out_next;

    logic            advance;
    logic            issue;
    logic            last_issue;
    logic            accept;
    logic            rd_en;
    logic            wr_en;
    logic [FA_W-1:0] fa_ext;
    logic [15:0]     origin_calc;
    logic            active_c;
    logic [15:0]     origin_c;
    logic [8:0]      left_c;
    logic [8:0]      left_dec;
    logic [8:0]      drawn_c;
    logic [7:0]      color_c;
    logic            done_c;

    // character code folded into the glyph range
    for (genvar i = 0; i < CODE_COUNT; i++)
    begin : g_code_mod
        assign code_mod[i] = GC_W'(i % GLYPH_COUNT);
    end

    assign cfg_ch.ready = 1'b1;
    assign out_ch.valid = out_valid_reg;
    assign out_ch.data  = out_reg;

    assign advance    = !out_valid_reg || out_ch.ready;
    assign issue      = (state_reg == ST_ROWS) && advance;
    assign last_issue = issue && (rows_left_reg == RL_W'(1));
    assign in_ch.ready = (state_reg == ST_IDLE) || last_issue;
    assign accept     = in_ch.valid && in_ch.ready;
    assign rd_en      = issue && !job_nul_reg;

    assign fa_ext = FA_W'(in_ch.data.font_address);
    assign wr_en  = accept && (in_ch.data.kind == KIND_FONT) && (fa_ext < FA_W'(STORE_SIZE));

    assign origin_calc = frame_base_reg
                       + 16'({8'd0, in_ch.data.y} * 16'(LINE_PITCH))
                       + 16'(in_ch.data.x);

    always_comb
    begin
        frame_base_next = frame_base_reg;
        if (cfg_ch.valid && cfg_ch.ready)
        begin
            frame_base_next = cfg_ch.data;
        end

        active_c = in_ch.data.string_start || active_reg;
        origin_c = in_ch.data.string_start ? origin_calc : origin_reg;
        left_c   = left_reg;
        if (in_ch.data.string_start)
        begin
            left_c = (in_ch.data.max_chars == 8'd0) ? LIMIT_FULL
                                                    : {1'b0, in_ch.data.max_chars};
        end
        drawn_c  = in_ch.data.string_start ? 9'd0 : drawn_reg;
        color_c  = in_ch.data.string_start ? in_ch.data.color : color_reg;
        left_dec = left_c - 9'd1;
        done_c   = (left_dec == 9'd0);

        state_next     = state_reg;
        origin_next    = origin_reg;
        left_next      = left_reg;
        drawn_next     = drawn_reg;
        color_next     = color_reg;
        active_next    = active_reg;
        rows_left_next = rows_left_reg;
        job_nul_next   = job_nul_reg;
        job_done_next  = job_done_reg;
        job_addr_next  = job_addr_reg;
        job_gidx_next  = job_gidx_reg;

        if (issue)
        begin
            rows_left_next = rows_left_reg - RL_W'(1);
            job_addr_next  = job_addr_reg + 16'(LINE_PITCH);
            job_gidx_next  = job_gidx_reg + STORE_AW'(1);
            if (last_issue)
            begin
                state_next = ST_IDLE;
            end
        end

        if (accept && (in_ch.data.kind == KIND_CHAR))
        begin
            origin_next = origin_c;
            left_next   = left_c;
            drawn_next  = drawn_c;
            color_next  = color_c;
            active_next = active_c;
            if (active_c)
            begin
                state_next    = ST_ROWS;
                job_addr_next = origin_c;
                if (in_ch.data.character == NUL_CODE)
                begin
                    active_next    = 1'b0;
                    rows_left_next = RL_W'(1);
                    job_nul_next   = 1'b1;
                    job_done_next  = 1'b1;
                end
                else
                begin
                    drawn_next     = drawn_c + 9'd1;
                    left_next      = left_dec;
                    active_next    = !done_c;
                    origin_next    = origin_c + CELL_WIDTH;
                    rows_left_next = RL_W'(GLYPH_ROWS);
                    job_nul_next   = 1'b0;
                    job_done_next  = done_c;
                    job_gidx_next  = STORE_AW'(code_mod[in_ch.data.character] * GLYPH_ROWS);
                end
            end
        end

        s1_valid_next = s1_valid_reg;
        s1_nul_next   = s1_nul_reg;
        s1_next       = s1_reg;
        if (advance)
        begin
            s1_valid_next = issue;
            if (issue)
            begin
                s1_nul_next            = job_nul_reg;
                s1_next.address        = job_addr_reg;
                s1_next.pixel_mask     = 8'd0;
                s1_next.pixel_color    = color_reg;
                s1_next.last_row       = (rows_left_reg == RL_W'(1));
                s1_next.string_done    = job_done_reg;
                s1_next.chars_consumed = drawn_reg;
            end
        end

        out_valid_next = out_valid_reg;
        out_next       = out_reg;
        if (advance)
        begin
            out_valid_next = s1_valid_reg;
            if (s1_valid_reg)
            begin
                out_next            = s1_reg;
                out_next.pixel_mask = s1_nul_reg ? 8'd0 : rd_data_reg;
            end
        end
    end

    // glyph memory, one write and one registered read port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            glyph_mem[fa_ext[STORE_AW-1:0]] <= in_ch.data.font_bits;
        end
        if (rd_en)
        begin
            rd_data_reg <= glyph_mem[job_gidx_reg];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            frame_base_reg <= 16'd0;
            origin_reg     <= 16'd0;
            left_reg       <= 9'd0;
            drawn_reg      <= 9'd0;
            color_reg      <= 8'd0;
            active_reg     <= 1'b0;
            rows_left_reg  <= '0;
            job_nul_reg    <= 1'b0;
            job_done_reg   <= 1'b0;
            s1_valid_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            frame_base_reg <= frame_base_next;
            origin_reg     <= origin_next;
            left_reg       <= left_next;
            drawn_reg      <= drawn_next;
            color_reg      <= color_next;
            active_reg     <= active_next;
            rows_left_reg  <= rows_left_next;
            job_nul_reg    <= job_nul_next;
            job_done_reg   <= job_done_next;
            s1_valid_reg   <= s1_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        job_addr_reg <= job_addr_next;
        job_gidx_reg <= job_gidx_next;
        s1_nul_reg   <= s1_nul_next;
        s1_reg       <= s1_next;
        out_reg      <= out_next;
    end

endmodule

// ===== tb/tb_font_text_blitter_8x8.sv =====
// ----------------------------------------------------------------------------
// tb_font_text_blitter_8x8
// self-checking bench for the 8x8 font text blitter: glyph loads, strings
// ended by NUL or by the character limit, restarts, stray characters and
// frame_base settings up to the 16-bit wrap, with random idling on both
// channels. every accepted transaction is run through a behavioural
// predictor of the row writes and each row write is checked in order
// ----------------------------------------------------------------------------
module tb_font_text_blitter_8x8;

    import ftb8_pkg::*;

    localparam int ROW_STRIDE     = 320;
    localparam int ROWS_PER_GLYPH = 8;
    localparam int STORE_DEPTH    = 2048;
    localparam int IDLE_PCT       = 24;
    localparam int SETTLE_CYCLES  = 8;
    localparam int CYCLE_LIMIT    = 500000;
    localparam int MAX_PRINTS     = 60;

    logic clk;
    logic rst_n;

    ftb8_stream_if #(.payload_t(ftb8_in_t))  in_ch ();
    ftb8_stream_if #(.payload_t(ftb8_out_t)) out_ch ();
    ftb8_stream_if #(.payload_t(ftb8_cfg_t)) cfg_ch ();

    font_text_blitter_8x8 uut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch),
        .cfg_ch (cfg_ch)
    );

    // predictor state
    logic [7:0]  glyph_mem [0:STORE_DEPTH-1];
    logic [15:0] frame_base_q;
    logic [15:0] pen_origin;
    logic [8:0]  chars_remaining;
    logic [8:0]  chars_so_far;
    logic [7:0]  pen_colour;
    logic        string_open;

    ftb8_out_t   pending_row_writes [$];
    logic [7:0]  loaded_codes [$];

    bit          quiet;
    int          errors = 0;
    int          cycle_count = 0;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    task automatic report_mismatch(input string what);
        if (errors < MAX_PRINTS)
            $display("error at cycle %0d: %s", cycle_count, what);
        errors++;
    endtask

    task automatic predict_row_writes(input ftb8_in_t item);
        ftb8_out_t w;
        logic      done;
        if (item.kind == KIND_FONT)
        begin
            glyph_mem[item.font_address] = item.font_bits;
            return;
        end
        if (item.string_start)
        begin
            pen_origin      = 16'(frame_base_q + item.y * ROW_STRIDE + item.x);
            pen_colour      = item.color;
            chars_remaining = (item.max_chars == 8'd0) ? LIMIT_FULL : {1'b0, item.max_chars};
            chars_so_far    = 9'd0;
            string_open     = 1'b1;
        end
        if (!string_open)
            return;
        if (item.character == NUL_CODE)
        begin
            string_open      = 1'b0;
            w.address        = pen_origin;
            w.pixel_mask     = 8'h00;
            w.pixel_color    = pen_colour;
            w.last_row       = 1'b1;
            w.string_done    = 1'b1;
            w.chars_consumed = chars_so_far;
            pending_row_writes.push_back(w);
            return;
        end
        chars_so_far    = chars_so_far + 9'd1;
        chars_remaining = chars_remaining - 9'd1;
        done            = (chars_remaining == 9'd0);
        if (done)
            string_open = 1'b0;
        for (int r = 0; r < ROWS_PER_GLYPH; r++)
        begin
            w.address        = 16'(pen_origin + r * ROW_STRIDE);
            w.pixel_mask     = glyph_mem[item.character * ROWS_PER_GLYPH + r];
            w.pixel_color    = pen_colour;
            w.last_row       = (r == ROWS_PER_GLYPH - 1);
            w.string_done    = done;
            w.chars_consumed = chars_so_far;
            pending_row_writes.push_back(w);
        end
        pen_origin = pen_origin + CELL_WIDTH;
    endtask

    // row write checker
    always @(posedge clk)
    begin
        ftb8_out_t want;
        ftb8_out_t got;
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            got = out_ch.data;
            if (pending_row_writes.size() == 0)
                report_mismatch($sformatf("row write with nothing expected, address %h",
                                          got.address));
            else
            begin
                want = pending_row_writes.pop_front();
                if (got.address !== want.address)
                    report_mismatch($sformatf("address %h, expected %h",
                                              got.address, want.address));
                if (got.pixel_mask !== want.pixel_mask)
                    report_mismatch($sformatf("pixel_mask %h, expected %h",
                                              got.pixel_mask, want.pixel_mask));
                if (got.pixel_color !== want.pixel_color)
                    report_mismatch($sformatf("pixel_color %h, expected %h",
                                              got.pixel_color, want.pixel_color));
                if (got.last_row !== want.last_row)
                    report_mismatch($sformatf("last_row %b, expected %b",
                                              got.last_row, want.last_row));
                if (got.string_done !== want.string_done)
                    report_mismatch($sformatf("string_done %b, expected %b",
                                              got.string_done, want.string_done));
                if (got.chars_consumed !== want.chars_consumed)
                    report_mismatch($sformatf("chars_consumed %0d, expected %0d",
                                              got.chars_consumed, want.chars_consumed));
            end
        end
    end

    // receiver stalls
    always @(posedge clk)
        out_ch.ready <= quiet || ($urandom_range(99) >= IDLE_PCT);

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("font_text_blitter_8x8 test failed");
            $finish;
        end
    end

    function automatic ftb8_in_t font_item(input logic [10:0] addr, input logic [7:0] bits);
        ftb8_in_t it;
        it.kind         = KIND_FONT;
        it.font_address = addr;
        it.font_bits    = bits;
        it.character    = 8'($urandom);
        it.string_start = 1'($urandom);
        it.x            = 9'($urandom_range(319));
        it.y            = 8'($urandom_range(199));
        it.color        = 8'($urandom);
        it.max_chars    = 8'($urandom);
        return it;
    endfunction

    function automatic ftb8_in_t char_item(input logic [7:0] code, input logic start,
                                           input logic [8:0] px, input logic [7:0] py,
                                           input logic [7:0] colour, input logic [7:0] lim);
        ftb8_in_t it;
        it.kind         = KIND_CHAR;
        it.font_address = 11'($urandom);
        it.font_bits    = 8'($urandom);
        it.character    = code;
        it.string_start = start;
        it.x            = px;
        it.y            = py;
        it.color        = colour;
        it.max_chars    = lim;
        return it;
    endfunction

    function automatic ftb8_in_t next_char(input logic [7:0] code);
        return char_item(code, 1'b0, 9'($urandom_range(319)), 8'($urandom_range(199)),
                         8'($urandom), 8'($urandom));
    endfunction

    function automatic logic [7:0] pick_code();
        return loaded_codes[$urandom_range(loaded_codes.size() - 1)];
    endfunction

    task automatic send_item(input ftb8_in_t item);
        in_ch.data  <= item;
        in_ch.valid <= 1'b1;
        do @(posedge clk); while (!in_ch.ready);
        predict_row_writes(item);
        if (!quiet && $urandom_range(99) < IDLE_PCT)
        begin
            in_ch.valid <= 1'b0;
            do @(posedge clk); while ($urandom_range(99) < IDLE_PCT);
        end
    endtask

    task automatic wait_idle;
        in_ch.valid <= 1'b0;
        while (pending_row_writes.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_frame_base(input ftb8_cfg_t value);
        cfg_ch.data  <= value;
        cfg_ch.valid <= 1'b1;
        do @(posedge clk); while (!cfg_ch.ready);
        cfg_ch.valid <= 1'b0;
        frame_base_q = value;
    endtask

    task automatic load_glyph(input logic [7:0] code, input logic [63:0] rows);
        bit known;
        known = 0;
        for (int r = 0; r < ROWS_PER_GLYPH; r++)
            send_item(font_item(11'(code * ROWS_PER_GLYPH + r), rows[63 - 8*r -: 8]));
        foreach (loaded_codes[i])
            if (loaded_codes[i] == code)
                known = 1;
        if (!known && code != NUL_CODE)
            loaded_codes.push_back(code);
    endtask

    // a string of drawn characters, optionally closed by NUL
    task automatic send_string(input logic [7:0] lim, input int len, input bit with_nul,
                               output int sent);
        logic [8:0] px;
        logic [7:0] py;
        logic [7:0] colour;
        px     = 9'($urandom_range(319));
        py     = 8'($urandom_range(199));
        colour = 8'($urandom);
        sent   = 0;
        for (int i = 0; i < len; i++)
        begin
            if (i == 0)
                send_item(char_item(pick_code(), 1'b1, px, py, colour, lim));
            else
                send_item(next_char(pick_code()));
            sent++;
        end
        if (with_nul || len == 0)
        begin
            send_item(char_item(NUL_CODE, len == 0, px, py, colour, lim));
            sent++;
        end
    endtask

    task automatic run_random_phase(input int quota);
        int sent;
        int n;
        int roll;
        logic [7:0] lim;
        sent = 0;
        while (sent < quota)
        begin
            roll = $urandom_range(99);
            if (roll < 8)
            begin
                load_glyph(8'($urandom), {$urandom, $urandom});
                sent += ROWS_PER_GLYPH;
            end
            else if (roll < 13)
            begin
                send_item(font_item(11'($urandom), 8'($urandom)));
                sent++;
            end
            else if (roll < 19)
            begin
                // stray character, drawn only if a string is still open
                send_item(next_char($urandom_range(1) ? pick_code() : NUL_CODE));
                sent++;
            end
            else
            begin
                roll = $urandom_range(99);
                if (roll < 70)
                    lim = 8'($urandom_range(1, 12));
                else if (roll < 85)
                    lim = 8'd0;
                else
                    lim = 8'($urandom_range(13, 255));
                send_string(lim, $urandom_range(0, 10), 1'($urandom_range(1)), n);
                sent += n;
            end
        end
    endtask

    task automatic test_glyph_setup;
        load_glyph(8'hFF, 64'h00FF_8001_AA55_C33C);
        load_glyph(8'h01, 64'hFF00_0180_55AA_3CC3);
    endtask

    task automatic test_directed_strings;
        wait_idle;
        write_frame_base(16'h0000);
        // character with no string open
        send_item(char_item(8'hFF, 1'b0, 9'd0, 8'd0, 8'hFF, 8'd0));
        // limit of two, then a character after the end
        send_item(char_item(8'hFF, 1'b1, 9'd0, 8'd0, 8'hFF, 8'd2));
        send_item(next_char(8'h01));
        send_item(next_char(8'hFF));
        // far corner, limit 256, closed by NUL
        send_item(char_item(8'h01, 1'b1, 9'd319, 8'd199, 8'h00, 8'd0));
        send_item(next_char(8'hFF));
        send_item(next_char(NUL_CODE));
        // NUL as the first character
        send_item(char_item(NUL_CODE, 1'b1, 9'd5, 8'd3, 8'hA5, 8'd1));
        // limit of one
        send_item(char_item(8'hFF, 1'b1, 9'd256, 8'd128, 8'h5A, 8'd1));
        // restart in the middle of a string
        send_item(char_item(8'h01, 1'b1, 9'd100, 8'd100, 8'h3C, 8'd5));
        send_item(char_item(8'hFF, 1'b1, 9'd192, 8'd64, 8'hC3, 8'd255));
        send_item(next_char(NUL_CODE));
        wait_idle;
        write_frame_base(16'hFFFF);
        send_item(char_item(8'hFF, 1'b1, 9'd319, 8'd199, 8'h81, 8'd3));
        send_item(next_char(8'h01));
        send_item(next_char(NUL_CODE));
    endtask

    task automatic test_back_to_back;
        wait_idle;
        write_frame_base(16'($urandom));
        quiet = 1;
        run_random_phase(20);
        wait_idle;
        quiet = 0;
    endtask

    task automatic test_full_limit;
        wait_idle;
        write_frame_base(16'($urandom));
        send_item(char_item(pick_code(), 1'b1, 9'($urandom_range(319)),
                            8'($urandom_range(199)), 8'($urandom), 8'd0));
        for (int i = 1; i < 256; i++)
            send_item(next_char(pick_code()));
        // string is closed now, so this one is dropped
        send_item(next_char(pick_code()));
    endtask

    task automatic test_random_traffic;
        for (int phase = 0; phase < 4; phase++)
        begin
            wait_idle;
            case (phase)
                1:       write_frame_base(16'hFFFF);
                2:       write_frame_base(16'h0000);
                default: write_frame_base(16'($urandom));
            endcase
            run_random_phase(10);
        end
    endtask

    initial
    begin
        rst_n           <= 1'b0;
        in_ch.valid     <= 1'b0;
        in_ch.data      <= '0;
        cfg_ch.valid    <= 1'b0;
        cfg_ch.data     <= '0;
        quiet           = 0;
        frame_base_q    = 16'h0000;
        pen_origin      = 16'h0000;
        chars_remaining = 9'd0;
        chars_so_far    = 9'd0;
        pen_colour      = 8'h00;
        string_open     = 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_glyph_setup;
        test_directed_strings;
        test_back_to_back;
        test_full_limit;
        test_random_traffic;

        wait_idle;
        repeat (20) @(posedge clk);
        if (errors == 0 && pending_row_writes.size() == 0)
            $display("font_text_blitter_8x8 test passed");
        else
            $display("font_text_blitter_8x8 test failed");
        $finish;
    end

endmodule

// ===== sim.f =====
hw/rtl/ftb8_pkg.sv
hw/rtl/ftb8_stream_if.sv
hw/rtl/font_text_blitter_8x8.sv
tb/tb_font_text_blitter_8x8.sv
